@@ hdl/length_prefixed_frame_parser_macros.svh @@
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_macros
// assertion helpers shared by the parser checks
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_PARSER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_MACROS_SVH

// concurrent check, switched off while reset is held
`define LPFP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent check that also runs through reset
`define LPFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/lpfp_pkg.sv @@
// ----------------------------------------------------------------------------
// lpfp_pkg
// types and constants of the length-prefixed frame parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpfp_pkg;

  localparam logic [7:0]  MARKER    = 8'd135;
  localparam logic [7:0]  COLON     = 8'h3a;
  localparam logic [31:0] MIN_FRAME = 32'd18;
  localparam logic [31:0] MAX_FRAME = 32'd4096;

  localparam int OFF_W = 13;

  // header offsets
  localparam logic [OFF_W-1:0] OFF_LEN_FIRST  = OFF_W'(2);
  localparam logic [OFF_W-1:0] OFF_LEN_LAST   = OFF_W'(5);
  localparam logic [OFF_W-1:0] OFF_TYPE_FIRST = OFF_W'(7);
  localparam logic [OFF_W-1:0] OFF_TYPE_LAST  = OFF_W'(10);
  localparam logic [OFF_W-1:0] OFF_SIZE_FIRST = OFF_W'(12);
  localparam logic [OFF_W-1:0] OFF_SIZE_LAST  = OFF_W'(15);
  localparam logic [OFF_W-1:0] OFF_HEAD_END   = OFF_W'(16);
  localparam logic [OFF_W-1:0] OFF_BODY       = OFF_W'(17);

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HEAD    = 3'd1,
    PH_SRC     = 3'd2,
    PH_DATA    = 3'd3,
    PH_SKIP    = 3'd4,
    PH_BADHEAD = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_SRC    = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_DROP   = 3'd3,
    KIND_DONE   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] msg_type;
    logic [31:0] data_size;
    logic [7:0]  byte_value;
    logic        last;
  } res_t;

  // up to two results made by one byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  function automatic res_t make_res(kind_t k, logic [31:0] t, logic [31:0] s,
                                    logic [7:0] b);
    res_t r;
    r.kind       = k;
    r.msg_type   = t;
    r.data_size  = s;
    r.byte_value = b;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

@@ hdl/length_prefixed_frame_parser.sv @@
// results: an accepted byte's results enter a four-entry result queue as the byte
// is taken and leave in order; a second result follows on the next output beat
// throughput: one byte per cycle while the queue has room, set by the single-pass
// parser state update; output sustains one result per cycle while out_tready is high
// reset: synchronous active-low rst_n returns the parser to marker hunting
// and empties the result queue
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// byte-stream parser for marker-started, length-prefixed frames
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] msg_type, [63:32] data_size, [71:64] byte_value
  output logic [2:0]  out_tuser,  // [2:0] out_kind
  output logic        out_tlast
);
  import lpfp_pkg::*;

  logic      in_fire;
  logic      out_fire;
  logic      q_room;
  logic      q_valid;
  res_pair_t res;
  res_t      head;

  assign in_tready = q_room;
  assign in_fire   = in_tvalid && q_room;
  assign out_fire  = q_valid && out_tready;

  lpfp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .res     (res)
  );

  lpfp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res),
    .pop       (out_fire),
    .head      (head),
    .not_empty (q_valid),
    .has_room  (q_room)
  );

  assign out_tvalid = q_valid;
  assign out_tdata  = {head.byte_value, head.data_size, head.msg_type};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

endmodule

@@ hdl/lpfp_core.sv @@
// ----------------------------------------------------------------------------
// lpfp_core
// per-byte frame state machine, produces up to two results per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          in_byte,
  output lpfp_pkg::res_pair_t res
);
  import lpfp_pkg::*;

  phase_t           phase_r,   phase_nxt;
  logic [OFF_W-1:0] offset_r,  offset_nxt;
  logic [31:0]      length_r,  length_nxt;
  logic [31:0]      type_r,    type_nxt;
  logic [31:0]      size_r,    size_nxt;
  logic [31:0]      left_r,    left_nxt;

  logic [31:0]      length_upd;
  logic [31:0]      size_upd;
  logic [31:0]      left_dec;
  logic [OFF_W-1:0] offset_inc;
  logic             bad_len;
  phase_t           ph_v;
  res_pair_t        res_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      offset_r <= '0;
      length_r <= '0;
      type_r   <= '0;
      size_r   <= '0;
      left_r   <= '0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      length_r <= length_nxt;
      type_r   <= type_nxt;
      size_r   <= size_nxt;
      left_r   <= left_nxt;
    end
  end

  assign length_upd = {length_r[23:0], in_byte};
  assign size_upd   = {size_r[23:0], in_byte};
  assign left_dec   = left_r - 32'd1;
  assign offset_inc = offset_r + OFF_W'(1);
  assign bad_len    = (length_upd > MAX_FRAME) || (length_upd < MIN_FRAME);

  always_comb begin
    phase_nxt  = phase_r;
    offset_nxt = offset_r;
    length_nxt = length_r;
    type_nxt   = type_r;
    size_nxt   = size_r;
    left_nxt   = left_r;
    ph_v       = phase_r;
    res_v      = '0;

    unique case (phase_r)
      PH_HUNT: begin
        if (in_byte == MARKER) begin
          phase_nxt  = PH_HEAD;
          offset_nxt = OFF_W'(1);
          length_nxt = '0;
          type_nxt   = '0;
          size_nxt   = '0;
          left_nxt   = '0;
        end
      end
      PH_HEAD, PH_BADHEAD: begin
        if (offset_r >= OFF_LEN_FIRST && offset_r <= OFF_LEN_LAST)
          length_nxt = length_upd;
        else if (offset_r >= OFF_TYPE_FIRST && offset_r <= OFF_TYPE_LAST)
          type_nxt = {type_r[23:0], in_byte};
        else if (offset_r >= OFF_SIZE_FIRST && offset_r <= OFF_SIZE_LAST)
          size_nxt = size_upd;

        if (offset_r == OFF_LEN_LAST && bad_len)
          ph_v = PH_BADHEAD;
        phase_nxt = ph_v;

        // size field completes on this byte, so take it straight from the beat
        if (offset_r == OFF_SIZE_LAST && ph_v == PH_HEAD) begin
          res_v.r0  = make_res(KIND_HEADER, type_r, size_upd, 8'd0);
          res_v.cnt = 2'd1;
        end

        if (offset_r == OFF_HEAD_END) begin
          if (ph_v == PH_BADHEAD) begin
            res_v.r0   = make_res(KIND_DROP, 32'd0, 32'd0, 8'd0);
            res_v.cnt  = 2'd1;
            phase_nxt  = PH_HUNT;
            offset_nxt = '0;
          end else begin
            phase_nxt  = PH_SRC;
            offset_nxt = OFF_BODY;
          end
        end else begin
          offset_nxt = offset_inc;
        end
      end
      PH_SRC, PH_DATA, PH_SKIP: begin
        if (phase_r == PH_SRC) begin
          if (in_byte == COLON) begin
            left_nxt = size_r;
            if (size_r == 32'd0) begin
              res_v.r0  = make_res(KIND_DONE, 32'd0, 32'd0, 8'd0);
              res_v.cnt = 2'd1;
              ph_v      = PH_SKIP;
            end else begin
              ph_v = PH_DATA;
            end
          end else begin
            res_v.r0  = make_res(KIND_SRC, 32'd0, 32'd0, in_byte);
            res_v.cnt = 2'd1;
          end
        end else if (phase_r == PH_DATA) begin
          res_v.r0  = make_res(KIND_DATA, 32'd0, 32'd0, in_byte);
          res_v.cnt = 2'd1;
          left_nxt  = left_dec;
          if (left_dec == 32'd0) begin
            res_v.r1  = make_res(KIND_DONE, 32'd0, 32'd0, 8'd0);
            res_v.cnt = 2'd2;
            ph_v      = PH_SKIP;
          end
        end
        phase_nxt  = ph_v;
        offset_nxt = offset_inc;

        // frame length reached: anything still owed becomes a drop
        if (32'(offset_inc) >= length_r) begin
          if (ph_v == PH_SRC || ph_v == PH_DATA) begin
            if (res_v.cnt == 2'd0) begin
              res_v.r0  = make_res(KIND_DROP, 32'd0, 32'd0, 8'd0);
              res_v.cnt = 2'd1;
            end else begin
              res_v.r1  = make_res(KIND_DROP, 32'd0, 32'd0, 8'd0);
              res_v.cnt = 2'd2;
            end
          end
          phase_nxt  = PH_HUNT;
          offset_nxt = '0;
        end
      end
      default: begin
        phase_nxt  = PH_HUNT;
        offset_nxt = '0;
      end
    endcase

    if (res_v.cnt == 2'd1)
      res_v.r0.last = 1'b1;
    else if (res_v.cnt == 2'd2)
      res_v.r1.last = 1'b1;
  end

  assign res = res_v;

endmodule

@@ hdl/lpfp_outq.sv @@
// ----------------------------------------------------------------------------
// lpfp_outq
// small result queue taking up to two results per cycle, one out per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfp_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpfp_pkg::res_pair_t push_data,
  input  logic                pop,
  output lpfp_pkg::res_t      head,
  output logic                not_empty,
  output logic                has_room
);
  import lpfp_pkg::*;

  res_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;
  logic [1:0]        n_push;

  assign n_push     = push ? push_data.cnt : 2'd0;
  assign wr_ptr_nxt = wr_ptr_r + QPTR_W'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
  assign count_nxt  = count_r + QCNT_W'(n_push) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0)
      q_r[wr_ptr_r] <= push_data.r0;
    if (n_push == 2'd2)
      q_r[wr_ptr_r + QPTR_W'(1)] <= push_data.r1;
  end

  assign head      = q_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  // a byte may bring two results, so keep two slots spare
  assign has_room  = (count_r <= QCNT_W'(QDEPTH - 2));

endmodule

@@ hdl/lpfp_checker.sv @@
// ----------------------------------------------------------------------------
// lpfp_checker
// port-level checks on the parser result stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "length_prefixed_frame_parser_macros.svh"

module lpfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import lpfp_pkg::*;

  // a stalled result beat holds
  `LPFP_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result beat changed while stalled")

  // header, drop and complete always close the results of their byte
  `LPFP_ASSERT(a_final_kinds, clk, rst_n, out_tvalid && (out_tuser == KIND_HEADER || out_tuser == KIND_DROP || out_tuser == KIND_DONE) |-> out_tlast, "closing result without tlast")

  // type and size fields only travel with a header
  `LPFP_ASSERT(a_hdr_fields, clk, rst_n, out_tvalid && out_tuser != KIND_HEADER |-> out_tdata[63:0] == 64'd0, "header fields set on non-header beat")

  // reset leaves the result queue empty
  `LPFP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "results present after reset")

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
